/* hdl/slab_object_allocator_core_assert.svh */
// Assertion macros for the slab object allocator core.
`ifndef SLAB_OBJECT_ALLOCATOR_CORE_ASSERT_SVH
`define SLAB_OBJECT_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SOA_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SOA_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SOA_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define SOA_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

/* hdl/soa_pkg.sv */
// Package with types and constants of the slab object allocator.
`timescale 1ns / 1ps
package soa_pkg;
  localparam int unsigned NumSlabs = 16;
  localparam int unsigned MaxObjs = 64;
  localparam int unsigned SlabW = $clog2(NumSlabs);
  localparam int unsigned SlotW = $clog2(MaxObjs);

  localparam logic [1:0] StatGrant = 2'd0;
  localparam logic [1:0] StatNoSlab = 2'd1;
  localparam logic [1:0] StatFreed = 2'd2;

  localparam logic ReqAlloc = 1'b0;
  localparam logic ReqFree = 1'b1;

  localparam logic CfgObjsPerSlab = 1'b0;
  localparam logic CfgSlabLimit = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [SlabW-1:0] free_slab;
    logic [SlotW-1:0] free_slot;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [SlabW-1:0] obj_slab;
    logic [SlotW-1:0] obj_slot;
  } rsp_t;

  typedef enum logic [3:0] {
    StIdle,
    StRead,
    StFresh,
    StPop,
    StPopWr,
    StLinkA,
    StLinkB,
    StLinkC,
    StDone
  } state_e;

  // Lists a slab can sit on.
  typedef enum logic [1:0] {
    LstPartial,
    LstFull,
    LstEmpty
  } list_e;
endpackage

/* hdl/soa_chain_mem.sv */
// Slot chain memory: registered synchronous read, one write port.
`timescale 1ns / 1ps
module soa_chain_mem #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10,
  parameter int unsigned DataW = 7
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);
  logic [DataW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* hdl/slab_object_allocator_core.sv */
// Top level of the slab object allocator core.
//
//  channel | ports                    | direction | beat
//  request | start, busy, req_i       | in        | start high while busy is low
//  result  | done_o, rsp_o            | out       | one-cycle strobe, no stall
//  config  | cfg_we_i, cfg_idx_i, ... | in        | write at each enabled edge
//
// A refused allocate or an ignored free goes from StRead straight to StDone.
// A plain free passes StPopWr and an allocate StPop and StPopWr; each list move
// adds StLinkA and StLinkC. A fresh slab sweeps its chain in StFresh, then StLinkC.
// A new start beat is taken in the cycle of the result strobe.
// After reset the lists are empty and no clearing pass is needed; results cannot stall.
`timescale 1ns / 1ps
module slab_object_allocator_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  soa_pkg::req_t     req_i,
  output logic              done_o,
  output soa_pkg::rsp_t     rsp_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [6:0]        cfg_data_i
);
  import soa_pkg::*;
`include "slab_object_allocator_core_assert.svh"

  localparam int unsigned SW = $clog2(NumSlabs) + 1;
  localparam int unsigned OW = $clog2(MaxObjs) + 1;
  localparam int unsigned CW = OW;
  localparam int unsigned AW = SW - 1 + OW - 1;
  localparam logic [SW-1:0] SNil = SW'(NumSlabs);
  localparam logic [OW-1:0] ONil = OW'(MaxObjs);

  state_e state_q, state_d;
  logic [6:0] objs_q;
  logic [4:0] limit_q;
  logic [SW-1:0] ph_q, fh_q, eh_q, ph_d, fh_d, eh_d;
  logic [SW-1:0] taken_q, taken_d;
  logic [SW-1:0] nxt_q [NumSlabs];
  logic [SW-1:0] prv_q [NumSlabs];
  logic [CW-1:0] tot_q [NumSlabs];
  logic [OW-1:0] chd_q [NumSlabs];
  req_t req_q;
  logic [SW-2:0] s_q, s_d;
  logic [OW-1:0] idx_q, idx_d;
  logic [CW-1:0] n_q, n_d;
  list_e from_q, from_d, to_q, to_d;
  logic move_q, move_d;
  rsp_t rsp_q, rsp_d;
  logic done_d;
  logic cwe;
  logic [AW-1:0] cwa, cra;
  logic [OW-1:0] cwd, crd;
  logic [CW-1:0] eff_objs;
  logic [SW-1:0] eff_lim;
  logic [SW-1:0] old_p, old_n;

  // Table write helpers.
  logic tw_en;
  logic [SW-2:0] tw_s;
  logic [CW-1:0] tw_tot;
  logic [OW-1:0] tw_chd;
  logic lk_en;
  logic [SW-1:0] lk_p, lk_n;

  always_comb begin
    eff_objs = (objs_q < 7'd2) ? CW'(2) : ((CW'(objs_q) > CW'(MaxObjs)) ? CW'(MaxObjs)
                                           : CW'(objs_q));
    eff_lim = (SW'(limit_q) > SW'(NumSlabs)) ? SW'(NumSlabs) : SW'(limit_q);
  end

  soa_chain_mem #(.Depth(NumSlabs * MaxObjs), .AddrW(AW), .DataW(OW)) u_mem (
    .clk_i, .we_i(cwe), .waddr_i(cwa), .wdata_i(cwd), .raddr_i(cra), .rdata_o(crd)
  );

  function automatic logic [SW-1:0] head_of(list_e l, logic [SW-1:0] p, logic [SW-1:0] f,
                                            logic [SW-1:0] e);
    logic [SW-1:0] r;
    case (l)
      LstPartial: r = p;
      LstFull: r = f;
      default: r = e;
    endcase
    return r;
  endfunction

  always_comb begin
    state_d = state_q;
    ph_d = ph_q;
    fh_d = fh_q;
    eh_d = eh_q;
    taken_d = taken_q;
    s_d = s_q;
    idx_d = idx_q;
    n_d = n_q;
    from_d = from_q;
    to_d = to_q;
    move_d = move_q;
    rsp_d = rsp_q;
    done_d = 1'b0;
    cwe = 1'b0;
    cwa = {s_q, idx_q[OW-2:0]};
    cwd = '0;
    cra = {s_q, chd_q[s_q][OW-2:0]};
    tw_en = 1'b0;
    tw_s = s_q;
    tw_tot = tot_q[s_q];
    tw_chd = chd_q[s_q];
    lk_en = 1'b0;
    lk_p = prv_q[s_q];
    lk_n = nxt_q[s_q];
    case (state_q)
      StIdle: begin
        if (start) begin
          state_d = StRead;
        end
      end
      StRead: begin
        rsp_d = '0;
        move_d = 1'b0;
        if (req_q.req_type == ReqAlloc) begin
          if (ph_q < SNil) begin
            s_d = ph_q[SW-2:0];
            state_d = (chd_q[ph_q[SW-2:0]] >= ONil) ? StDone : StPop;
            rsp_d.status = (chd_q[ph_q[SW-2:0]] >= ONil) ? StatNoSlab : StatGrant;
          end else if (eh_q < SNil) begin
            s_d = eh_q[SW-2:0];
            if (chd_q[eh_q[SW-2:0]] >= ONil) begin
              rsp_d.status = StatNoSlab;
              state_d = StDone;
            end else begin
              from_d = LstEmpty;
              to_d = LstPartial;
              move_d = 1'b1;
              state_d = StLinkA;
            end
          end else if (taken_q < eff_lim) begin
            s_d = taken_q[SW-2:0];
            taken_d = taken_q + 1'b1;
            idx_d = '0;
            n_d = eff_objs;
            state_d = StFresh;
          end else begin
            rsp_d.status = StatNoSlab;
            state_d = StDone;
          end
        end else begin
          rsp_d.status = StatFreed;
          s_d = req_q.free_slab[SW-2:0];
          if (SW'(req_q.free_slab) >= SNil || SW'(req_q.free_slab) >= taken_q ||
              OW'(req_q.free_slot) >= ONil) begin
            state_d = StDone;
          end else begin
            state_d = StPopWr;
          end
        end
      end
      StFresh: begin
        cwe = 1'b1;
        cwd = (CW'(idx_q) + 1'b1 == n_q) ? ONil : idx_q + 1'b1;
        idx_d = idx_q + 1'b1;
        if (CW'(idx_q) + 1'b1 == n_q) begin
          tw_en = 1'b1;
          tw_tot = n_q;
          tw_chd = '0;
          lk_en = 1'b1;
          lk_p = SNil;
          lk_n = SNil;
          from_d = LstPartial;
          to_d = LstPartial;
          state_d = StLinkC;
        end
      end
      StPop: begin
        state_d = StPopWr;
      end
      StPopWr: begin
        tw_en = 1'b1;
        if (req_q.req_type == ReqAlloc) begin
          rsp_d.obj_slab = SlabW'(s_q);
          rsp_d.obj_slot = SlotW'(chd_q[s_q]);
          tw_chd = crd;
          tw_tot = tot_q[s_q] - 1'b1;
          if (tw_tot == '0) begin
            from_d = LstPartial;
            to_d = LstFull;
            move_d = 1'b1;
          end
        end else begin
          cwe = 1'b1;
          cwa = {s_q, req_q.free_slot[OW-2:0]};
          cwd = chd_q[s_q];
          tw_chd = OW'(req_q.free_slot);
          tw_tot = tot_q[s_q] + 1'b1;
          if (tw_tot == CW'(1)) begin
            from_d = LstFull;
            to_d = LstPartial;
            move_d = 1'b1;
          end else if (tw_tot == eff_objs) begin
            from_d = LstPartial;
            to_d = LstEmpty;
            move_d = 1'b1;
          end
        end
        state_d = move_d ? StLinkA : StDone;
      end
      StLinkA: begin
        // Unlink from the source list.
        lk_en = 1'b1;
        lk_p = SNil;
        lk_n = SNil;
        case (from_q)
          LstPartial: if (ph_q == SW'(s_q)) ph_d = nxt_q[s_q];
          LstFull: if (fh_q == SW'(s_q)) fh_d = nxt_q[s_q];
          default: if (eh_q == SW'(s_q)) eh_d = nxt_q[s_q];
        endcase
        state_d = StLinkC;
      end
      StLinkC: begin
        // Push at the head of the target list.
        lk_en = 1'b1;
        lk_p = SNil;
        lk_n = head_of(to_q, ph_q, fh_q, eh_q);
        case (to_q)
          LstPartial: ph_d = SW'(s_q);
          LstFull: fh_d = SW'(s_q);
          default: eh_d = SW'(s_q);
        endcase
        move_d = 1'b0;
        if (req_q.req_type == ReqAlloc && rsp_q.status == StatGrant &&
            !(from_q == LstPartial && to_q == LstFull)) begin
          state_d = StPop;
        end else begin
          state_d = StDone;
        end
      end
      StDone: begin
        done_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign old_p = prv_q[s_q];
  assign old_n = nxt_q[s_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      objs_q <= 7'd64;
      limit_q <= 5'd16;
      ph_q <= SNil;
      fh_q <= SNil;
      eh_q <= SNil;
      taken_q <= '0;
      done_o <= 1'b0;
      move_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q <= ph_d;
      fh_q <= fh_d;
      eh_q <= eh_d;
      taken_q <= taken_d;
      done_o <= done_d;
      move_q <= move_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgObjsPerSlab) objs_q <= cfg_data_i;
        if (cfg_idx_i == CfgSlabLimit) limit_q <= cfg_data_i[4:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start) req_q <= req_i;
    s_q <= s_d;
    idx_q <= idx_d;
    n_q <= n_d;
    from_q <= from_d;
    to_q <= to_d;
    rsp_q <= rsp_d;
    if (tw_en) begin
      tot_q[tw_s] <= tw_tot;
      chd_q[tw_s] <= tw_chd;
    end
    if (lk_en) begin
      if (state_q == StLinkA) begin
        if (old_p < SNil) nxt_q[old_p[SW-2:0]] <= old_n;
        if (old_n < SNil) prv_q[old_n[SW-2:0]] <= old_p;
      end
      prv_q[s_q] <= lk_p;
      nxt_q[s_q] <= lk_n;
      if (state_q == StLinkC && lk_n < SNil) prv_q[lk_n[SW-2:0]] <= SW'(s_q);
    end
  end

  assign busy = (state_q != StIdle);
  assign rsp_o = rsp_q;

  `SOA_ASSERT_IMPL(a_done_pulse, clk_i, rst_ni, done_o |=> !done_o, "result strobe held")
  `SOA_ASSERT_IMPL(a_done_busy, clk_i, rst_ni, done_o |-> !busy, "result while busy")
  `SOA_ASSERT_NEVER(a_taken, clk_i, rst_ni, taken_q > SW'(NumSlabs), "slab count overflow")
endmodule

/* dv/slab_pool_checker.sv */
// Checker that predicts and compares every result beat of the slab allocator.
`timescale 1ns / 1ps
module slab_pool_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          busy,
  input  soa_pkg::req_t req_i,
  input  logic          done_i,
  input  soa_pkg::rsp_t rsp_i,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [6:0]    cfg_data_i,
  output int            pending_o,
  output int            fail_count_o
);
  import soa_pkg::*;

  localparam logic [4:0] SlabNil = 5'd16;
  localparam logic [6:0] SlotNil = 7'd64;

  logic [6:0] objs_per_slab;
  logic [4:0] slab_limit;
  logic [4:0] lst_hd [3];
  logic [4:0] fresh_taken;
  logic [4:0] link_next [16];
  logic [4:0] link_prev [16];
  logic [6:0] free_total [16];
  logic [6:0] chain_head [16];
  logic [6:0] chain_next [1024];
  rsp_t       expected_rsp_q [$];

  function automatic logic [6:0] used_objs();
    if (objs_per_slab < 7'd2) return 7'd2;
    if (objs_per_slab > 7'd64) return 7'd64;
    return objs_per_slab;
  endfunction

  function automatic logic [4:0] used_limit();
    return (slab_limit > 5'd16) ? 5'd16 : slab_limit;
  endfunction

  task automatic unlink_slab(input list_e lst, input logic [4:0] s);
    logic [4:0] p;
    logic [4:0] n;
    p = link_prev[s[3:0]];
    n = link_next[s[3:0]];
    if (p < SlabNil) link_next[p[3:0]] = n;
    if (n < SlabNil) link_prev[n[3:0]] = p;
    if (lst_hd[lst] == s) lst_hd[lst] = n;
    link_prev[s[3:0]] = SlabNil;
    link_next[s[3:0]] = SlabNil;
  endtask

  task automatic push_slab(input list_e lst, input logic [4:0] s);
    link_next[s[3:0]] = lst_hd[lst];
    link_prev[s[3:0]] = SlabNil;
    if (lst_hd[lst] < SlabNil) link_prev[lst_hd[lst][3:0]] = s;
    lst_hd[lst] = s;
  endtask

  task automatic predict_slab_op(input req_t r, output rsp_t e);
    logic [4:0] s;
    logic [6:0] slot;
    logic [6:0] n;
    int i;
    e = '0;
    if (r.req_type == ReqAlloc) begin
      if (lst_hd[LstPartial] < SlabNil) begin
        s = lst_hd[LstPartial];
        if (chain_head[s[3:0]] >= SlotNil) begin
          e.status = StatNoSlab;
          return;
        end
      end else if (lst_hd[LstEmpty] < SlabNil) begin
        s = lst_hd[LstEmpty];
        if (chain_head[s[3:0]] >= SlotNil) begin
          e.status = StatNoSlab;
          return;
        end
        unlink_slab(LstEmpty, s);
        push_slab(LstPartial, s);
      end else if (fresh_taken < used_limit()) begin
        n = used_objs();
        s = fresh_taken;
        fresh_taken = fresh_taken + 5'd1;
        free_total[s[3:0]] = n;
        chain_head[s[3:0]] = '0;
        for (i = 0; i + 1 < n; i++) chain_next[s[3:0] * 64 + i] = 7'(i + 1);
        chain_next[s[3:0] * 64 + n - 1] = SlotNil;
        link_next[s[3:0]] = SlabNil;
        link_prev[s[3:0]] = SlabNil;
        push_slab(LstPartial, s);
      end else begin
        e.status = StatNoSlab;
        return;
      end
      slot = chain_head[s[3:0]];
      chain_head[s[3:0]] = chain_next[{s[3:0], slot[5:0]}];
      free_total[s[3:0]] = free_total[s[3:0]] - 7'd1;
      if (free_total[s[3:0]] == 7'd0) begin
        unlink_slab(LstPartial, s);
        push_slab(LstFull, s);
      end
      e.status = StatGrant;
      e.obj_slab = s[3:0];
      e.obj_slot = slot[5:0];
    end else begin
      e.status = StatFreed;
      if ({1'b0, r.free_slab} >= fresh_taken) return;
      s = {1'b0, r.free_slab};
      chain_next[{r.free_slab, r.free_slot}] = chain_head[s[3:0]];
      chain_head[s[3:0]] = {1'b0, r.free_slot};
      free_total[s[3:0]] = free_total[s[3:0]] + 7'd1;
      if (free_total[s[3:0]] == 7'd1) begin
        unlink_slab(LstFull, s);
        push_slab(LstPartial, s);
      end else if (free_total[s[3:0]] == used_objs()) begin
        unlink_slab(LstPartial, s);
        push_slab(LstEmpty, s);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t e;
    if (!rst_ni) begin
      objs_per_slab = 7'd64;
      slab_limit = 5'd16;
      lst_hd[0] = SlabNil;
      lst_hd[1] = SlabNil;
      lst_hd[2] = SlabNil;
      fresh_taken = '0;
      expected_rsp_q.delete();
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (done_i) begin
        if (expected_rsp_q.size() == 0) begin
          if (fail_count_o < 10) $display("Unexpected result beat: %p", rsp_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_rsp_q.pop_front();
          if (rsp_i.status !== e.status || rsp_i.obj_slab !== e.obj_slab ||
              rsp_i.obj_slot !== e.obj_slot) begin
            if (fail_count_o < 10)
              $display("Mismatch: expected %p, got %p", e, rsp_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (start && !busy) begin
        predict_slab_op(req_i, e);
        expected_rsp_q.push_back(e);
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgObjsPerSlab) objs_per_slab = cfg_data_i;
        else slab_limit = cfg_data_i[4:0];
      end
      pending_o <= expected_rsp_q.size();
    end
  end
endmodule

/* dv/slab_object_allocator_core_test.sv */
// Testbench top that drives requests and configuration into the slab allocator.
`timescale 1ns / 1ps
module slab_object_allocator_core_test;
  import soa_pkg::*;

  localparam int CycleLimit = 1000000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  req_t       req_i = '0;
  logic       done_o;
  rsp_t       rsp_o;
  logic       cfg_we_i = 1'b0;
  logic       cfg_idx_i = CfgObjsPerSlab;
  logic [6:0] cfg_data_i = '0;
  int         pending;
  int         fail_count;
  int         cycle_count = 0;
  int         burst_left = 0;
  rsp_t       live_objs [$];

  slab_object_allocator_core dut (.*);

  slab_pool_checker checker_i (
    .clk_i, .rst_ni, .start, .busy, .req_i, .done_i(done_o), .rsp_i(rsp_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .pending_o(pending), .fail_count_o(fail_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (done_o && rsp_o.status == StatGrant) live_objs.push_back(rsp_o);
  end

  task automatic send_beat(input req_t r);
    logic taken;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
    burst_left--;
    start <= 1'b1;
    req_i <= r;
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0 || busy);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [6:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic free_live();
    req_t r;
    int k;
    k = $urandom_range(live_objs.size() - 1);
    r.req_type = ReqFree;
    r.free_slab = live_objs[k].obj_slab;
    r.free_slot = live_objs[k].obj_slot;
    live_objs.delete(k);
    send_beat(r);
  endtask

  initial begin
    logic [6:0] objs_set [7] = '{7'd64, 7'd2, 7'd5, 7'd127, 7'd0, 7'd17, 7'd64};
    logic [6:0] limit_set [7] = '{7'd16, 7'd1, 7'd3, 7'd31, 7'd0, 7'd16, 7'd2};
    req_t r;
    int pick;
    int alloc_pct;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    r = '0;
    repeat (4) send_beat(r);
    r = '{ReqFree, 4'd15, 6'd63};
    send_beat(r);
    r = '{ReqFree, 4'd0, 6'd63};
    send_beat(r);
    r = '{ReqAlloc, 4'd15, 6'd63};
    send_beat(r);
    wait_idle();
    while (live_objs.size() != 0) free_live();
    r = '{ReqFree, 4'd1, 6'd0};
    send_beat(r);
    r = '0;
    repeat (3) send_beat(r);

    for (int ph = 0; ph < 7; ph++) begin
      wait_idle();
      write_reg(CfgObjsPerSlab, objs_set[ph]);
      write_reg(CfgSlabLimit, limit_set[ph]);
      for (int i = 0; i < 270; i++) begin
        alloc_pct = ((i / 45) % 2 == 0) ? 70 : 30;
        pick = $urandom_range(99);
        if (pick < 12) begin
          r.req_type = ReqFree;
          r.free_slab = 4'($urandom);
          r.free_slot = 6'($urandom);
          send_beat(r);
        end else if (pick < 12 + alloc_pct || live_objs.size() == 0) begin
          r = '0;
          r.free_slab = 4'($urandom);
          r.free_slot = 6'($urandom);
          send_beat(r);
        end else begin
          free_live();
        end
      end
    end

    wait_idle();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
